[rtl/core/mtb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mtb_pkg;

  // field and state widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned TotalW  = 10;
  localparam int unsigned SumW    = 32;
  localparam int unsigned CountW  = 23;
  localparam int unsigned AvgW    = 10;
  localparam int unsigned LevelW  = 8;

  // frame capacity in pixels
  localparam int unsigned MaxPixels = 4194304;

  // divider: one quotient bit per step, quotient never exceeds 765
  localparam int unsigned DivSteps = AvgW;
  localparam int unsigned StepW    = $clog2(DivSteps);
  localparam int unsigned DivShift = AvgW - 1;

  // output levels
  localparam logic [LevelW-1:0] LevelHigh = 8'd255;
  localparam logic [LevelW-1:0] LevelLow  = 8'd0;

  // command codes
  localparam logic CmdAccumulate = 1'b0;
  localparam logic CmdClassify   = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic accum;
    logic classify;
    logic div_load;
    logic div_step;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

[rtl/core/mtb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mtb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             command_i,
  input  wire logic             last_i,
  output mtb_pkg::ctrl_cmd_t    cmd_o,
  output logic                  busy_o,
  output logic                  level_valid_o
);
  import mtb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } state_e;

  state_e            state_q;
  logic [StepW-1:0]  step_q;
  logic              busy_q;
  logic              valid_q;
  logic              accept;

  // a word is taken only while no division runs
  assign accept = start_i & ~busy_q;

  // datapath commands
  assign cmd_o.accum    = accept & (command_i == CmdAccumulate);
  assign cmd_o.classify = accept & (command_i == CmdClassify);
  assign cmd_o.div_load = (state_q == ST_LOAD);
  assign cmd_o.div_step = (state_q == ST_DIV);

  assign busy_o        = busy_q;
  assign level_valid_o = valid_q;

  // state, step counter and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_o.classify;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.accum && last_i) begin
            state_q <= ST_LOAD;
            busy_q  <= 1'b1;
          end
        end
        ST_LOAD: begin
          state_q <= ST_DIV;
          step_q  <= '0;
        end
        ST_DIV: begin
          if (step_q == StepW'(DivSteps - 1)) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/mtb_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module mtb_dpath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mtb_pkg::ctrl_cmd_t           cmd_i,
  input  wire logic [mtb_pkg::ChanW-1:0]    red_i,
  input  wire logic [mtb_pkg::ChanW-1:0]    green_i,
  input  wire logic [mtb_pkg::ChanW-1:0]    blue_i,
  input  wire logic                         last_i,
  output logic      [mtb_pkg::LevelW-1:0]   level_o
);
  import mtb_pkg::*;

  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AvgW-1:0]   avg_q;
  logic              done_q;
  logic [SumW-1:0]   rem_q;
  logic [SumW-1:0]   dvs_q;
  logic [LevelW-1:0] level_q;

  logic [TotalW-1:0] total;
  logic [SumW-1:0]   sum_base;
  logic [CountW-1:0] count_base;
  logic              qbit;

  // pixel channel total
  assign total = TotalW'(red_i) + TotalW'(green_i) + TotalW'(blue_i);

  // accumulate, restarting the frame after a finished pass
  always_comb begin
    sum_base   = done_q ? '0 : sum_q;
    count_base = done_q ? '0 : count_q;
    if (count_base < CountW'(MaxPixels)) begin
      sum_d   = sum_base + SumW'(total);
      count_d = count_base + CountW'(1);
    end else begin
      sum_d   = sum_base;
      count_d = count_base;
    end
  end

  // restoring divide step; an empty count yields zero
  assign qbit = (count_q != '0) && (rem_q >= dvs_q);

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      avg_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.accum) begin
        sum_q   <= sum_d;
        count_q <= count_d;
        done_q  <= last_i;
      end
      if (cmd_i.div_load) begin
        avg_q <= '0;
      end else if (cmd_i.div_step) begin
        avg_q <= {avg_q[AvgW-2:0], qbit};
      end
    end
  end

  // divider working registers and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= sum_q;
      dvs_q <= {count_q, DivShift'(0)};
    end else if (cmd_i.div_step) begin
      if (qbit) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.classify) begin
      level_q <= (avg_q > total) ? LevelLow : LevelHigh;
    end
  end

  assign level_o = level_q;

endmodule

`default_nettype wire

[rtl/core/mean_threshold_binarizer_core.sv]
// mean threshold binarizer
// input channel: a pixel word (command, red, green, blue, last) is taken at
// a rising clock edge with start high and busy low.
// accumulate words (command 0) add red+green+blue to the frame sum and count
// the pixel, up to the frame capacity; the word marked last ends the pass.
// the next accumulate word after a finished pass starts a new frame.
// classify words (command 1) give level_o = 0 when the frame average exceeds
// red+green+blue, else 255, with level_valid_o high for one cycle, in the cycle
// after the word is taken. accumulate words give no result.
// throughput: one word per cycle, except after a last word: busy then stays
// high while the average is formed by a restoring divider that
// yields one quotient bit per cycle (a load state, then 10 steps).
// the receiver cannot stall; each result is valid for exactly one cycle.
// reset clears the sum, count, average and pass flag; classify before any
// pass therefore gives 255.
`timescale 1ns / 1ps
`default_nettype none

module mean_threshold_binarizer_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        command_i,
  input  wire logic [mtb_pkg::ChanW-1:0]   red_i,
  input  wire logic [mtb_pkg::ChanW-1:0]   green_i,
  input  wire logic [mtb_pkg::ChanW-1:0]   blue_i,
  input  wire logic                        last_i,
  output logic                             level_valid_o,
  output logic      [mtb_pkg::LevelW-1:0]  level_o
);
  import mtb_pkg::*;

  ctrl_cmd_t cmd;

  // sequencer
  mtb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .command_i     (command_i),
    .last_i        (last_i),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .level_valid_o (level_valid_o)
  );

  // accumulators, divider and compare
  mtb_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .last_i  (last_i),
    .level_o (level_o)
  );

endmodule

`default_nettype wire
